### rtl/line_maze_path_recorder_defines.svh
// Assertion macros used by the checker file.
`ifndef LINE_MAZE_PATH_RECORDER_DEFINES_SVH
`define LINE_MAZE_PATH_RECORDER_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define LMPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define LMPR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/lmpr_pkg.sv
package lmpr_pkg;

  localparam int PATH_DEPTH_C = 64;
  localparam int PCNT_W = 7;

  // Turn codes
  localparam logic [2:0] T_STRAIGHT = 3'd0;
  localparam logic [2:0] T_LEFT90   = 3'd1;
  localparam logic [2:0] T_RIGHT90  = 3'd2;
  localparam logic [2:0] T_LEFT180  = 3'd3;
  localparam logic [2:0] T_RIGHT180 = 3'd4;
  localparam logic [2:0] T_FINISH   = 3'd5;
  localparam logic [2:0] T_STOP     = 3'd6;

  // Line kinds
  localparam logic [2:0] K_NONE     = 3'd0;
  localparam logic [2:0] K_LEFT     = 3'd1;
  localparam logic [2:0] K_RIGHT    = 3'd2;
  localparam logic [2:0] K_STRAIGHT = 3'd3;
  localparam logic [2:0] K_FULL     = 3'd4;

  // Opcodes
  localparam logic [2:0] OP_FWD    = 3'd0;
  localparam logic [2:0] OP_BWD    = 3'd1;
  localparam logic [2:0] OP_DEAD   = 3'd2;
  localparam logic [2:0] OP_SOLVE  = 3'd3;
  localparam logic [2:0] OP_REPLAY = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FAILED = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Microcode addresses
  localparam int UPC_W = 5;
  localparam logic [UPC_W-1:0] A_IDLE = 5'd0;
  localparam logic [UPC_W-1:0] A_DISP = 5'd1;
  localparam logic [UPC_W-1:0] A_REC0 = 5'd2;
  localparam logic [UPC_W-1:0] A_REC1 = 5'd3;
  localparam logic [UPC_W-1:0] A_REC2 = 5'd4;
  localparam logic [UPC_W-1:0] A_REC3 = 5'd5;
  localparam logic [UPC_W-1:0] A_REC4 = 5'd6;
  localparam logic [UPC_W-1:0] A_REC5 = 5'd7;
  localparam logic [UPC_W-1:0] A_SOL0 = 5'd8;
  localparam logic [UPC_W-1:0] A_SOL1 = 5'd9;
  localparam logic [UPC_W-1:0] A_SOL2 = 5'd10;
  localparam logic [UPC_W-1:0] A_SOL3 = 5'd11;
  localparam logic [UPC_W-1:0] A_SOL4 = 5'd12;
  localparam logic [UPC_W-1:0] A_SOL5 = 5'd13;
  localparam logic [UPC_W-1:0] A_RPL0 = 5'd14;
  localparam logic [UPC_W-1:0] A_RPL1 = 5'd15;
  localparam logic [UPC_W-1:0] A_CLR0 = 5'd16;
  localparam logic [UPC_W-1:0] A_EMIT = 5'd17;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_DISPATCH,
    COND_LT3,
    COND_NOT_U,
    COND_CNT_ZERO,
    COND_MORE,
    COND_RPOS_END,
    COND_OUT_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    CLS_EMIT,
    CLS_RECORD,
    CLS_SOLVE,
    CLS_REPLAY,
    CLS_CLEAR
  } dcls_e;

  typedef enum logic [2:0] {
    WD_REC,
    WD_STOP,
    WD_RED,
    WD_SWAP_RD,
    WD_SWAP_TMP
  } wd_sel_e;

  typedef enum logic [1:0] {
    WA_CNT_M3,
    WA_I,
    WA_J
  } wa_sel_e;

  typedef enum logic [2:0] {
    RA_CNT_M1,
    RA_CNT_M2,
    RA_CNT_M3,
    RA_I,
    RA_I_NEXT,
    RA_J,
    RA_RPOS
  } ra_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  // One control word of the sequencer program
  typedef struct packed {
    logic             accept;
    cond_e            cond;
    logic [UPC_W-1:0] target;
    logic             ret;
    logic             ld_sel;
    logic             add_en;
    wd_sel_e          wd_sel;
    wa_sel_e          wa_sel;
    logic             we;
    ra_sel_e          ra_sel;
    acc_op_e          acc_op;
    logic             sub2;
    logic             solve_init;
    logic             tmp_ld;
    logic             step_ij;
    logic             rpos_clr;
    logic             rpos_inc;
    logic             t_ld_rd;
    logic             clr;
    logic             out_ld;
  } cw_t;

  // Datapath conditions seen by the sequencer
  typedef struct packed {
    dcls_e cls;
    logic  lt3;
    logic  not_u;
    logic  cnt_zero;
    logic  more;
    logic  rpos_end;
    logic  out_busy;
  } flags_t;

  function automatic logic [2:0] sel_fwd(input logic [2:0] p, input logic [2:0] c,
                                         input logic lh);
    logic [2:0] t;
    t = T_STOP;
    if (p == K_NONE && c == K_NONE) t = lh ? T_RIGHT180 : T_LEFT180;
    else if (p == K_FULL && c == K_NONE) t = lh ? T_LEFT90 : T_RIGHT90;
    else if (p == K_RIGHT && c == K_NONE) t = T_RIGHT90;
    else if (p == K_LEFT && c == K_NONE) t = T_LEFT90;
    else if (p == K_FULL && c == K_STRAIGHT) t = lh ? T_LEFT90 : T_RIGHT90;
    else if (p == K_FULL && c == K_FULL) t = T_FINISH;
    else if (p == K_RIGHT && c == K_STRAIGHT) t = lh ? T_STRAIGHT : T_RIGHT90;
    else if (p == K_LEFT && c == K_STRAIGHT) t = lh ? T_LEFT90 : T_STRAIGHT;
    return t;
  endfunction

  function automatic logic [2:0] sel_bwd(input logic [2:0] p, input logic [2:0] c,
                                         input logic lh);
    logic [2:0] t;
    t = T_STOP;
    if (p == K_LEFT && c == K_NONE) t = T_LEFT90;
    else if (p == K_RIGHT && c == K_NONE) t = T_RIGHT90;
    else if (p == K_RIGHT && c == K_STRAIGHT) t = lh ? T_RIGHT90 : T_LEFT180;
    else if (p == K_LEFT && c == K_STRAIGHT) t = lh ? T_RIGHT180 : T_LEFT90;
    else if (p == K_FULL && (c == K_NONE || c == K_STRAIGHT)) t = lh ? T_RIGHT90 : T_LEFT90;
    return t;
  endfunction

  function automatic logic [2:0] mirror_turn(input logic [2:0] t);
    logic [2:0] m;
    m = T_STOP;
    if (t == T_LEFT90) m = T_RIGHT90;
    else if (t == T_RIGHT90) m = T_LEFT90;
    else if (t == T_LEFT180 || t == T_RIGHT180 || t == T_STRAIGHT) m = T_STRAIGHT;
    return m;
  endfunction

  function automatic logic [2:0] swap_sides(input logic [2:0] t);
    logic [2:0] m;
    m = t;
    if (t == T_LEFT90) m = T_RIGHT90;
    else if (t == T_RIGHT90) m = T_LEFT90;
    return m;
  endfunction

  // Angle in quarter turns clockwise
  function automatic logic [1:0] quarter_of(input logic [2:0] t);
    logic [1:0] q;
    q = 2'd0;
    if (t == T_LEFT90) q = 2'd3;
    else if (t == T_RIGHT90) q = 2'd1;
    else if (t == T_LEFT180 || t == T_RIGHT180) q = 2'd2;
    return q;
  endfunction

  function automatic logic [2:0] turn_of_quarter(input logic [1:0] q);
    logic [2:0] t;
    case (q)
      2'd1:    t = T_RIGHT90;
      2'd2:    t = T_LEFT180;
      2'd3:    t = T_LEFT90;
      default: t = T_STRAIGHT;
    endcase
    return t;
  endfunction

  function automatic logic [UPC_W-1:0] dispatch_target(input dcls_e cls);
    logic [UPC_W-1:0] a;
    unique case (cls)
      CLS_RECORD: a = A_REC0;
      CLS_SOLVE:  a = A_SOL0;
      CLS_REPLAY: a = A_RPL0;
      CLS_CLEAR:  a = A_CLR0;
      default:    a = A_EMIT;
    endcase
    return a;
  endfunction

  // Microcode program
  function automatic cw_t ucode(input logic [UPC_W-1:0] a);
    cw_t cw;
    cw = '0;
    unique case (a)
      A_IDLE: begin
        cw.accept = 1'b1;
        cw.cond   = COND_NO_IN;
        cw.target = A_IDLE;
      end
      A_DISP: begin
        cw.ld_sel = 1'b1;
        cw.cond   = COND_DISPATCH;
      end
      // record, then fold a U-turn between two turns
      A_REC0: begin
        cw.add_en = 1'b1;
        cw.wd_sel = WD_REC;
      end
      A_REC1: begin
        cw.cond   = COND_LT3;
        cw.target = A_EMIT;
      end
      A_REC2: begin
        cw.ra_sel = RA_CNT_M2;
      end
      A_REC3: begin
        cw.acc_op = ACC_LOAD;
        cw.ra_sel = RA_CNT_M1;
        cw.cond   = COND_NOT_U;
        cw.target = A_EMIT;
      end
      A_REC4: begin
        cw.acc_op = ACC_ADD;
        cw.ra_sel = RA_CNT_M3;
      end
      A_REC5: begin
        cw.we     = 1'b1;
        cw.wa_sel = WA_CNT_M3;
        cw.wd_sel = WD_RED;
        cw.sub2   = 1'b1;
        cw.cond   = COND_ALWAYS;
        cw.target = A_EMIT;
      end
      // solve: swap ends inward, then append stop
      A_SOL0: begin
        cw.solve_init = 1'b1;
        cw.cond       = COND_CNT_ZERO;
        cw.target     = A_SOL5;
      end
      A_SOL1: begin
        cw.ra_sel = RA_I;
      end
      A_SOL2: begin
        cw.ra_sel = RA_J;
        cw.tmp_ld = 1'b1;
      end
      A_SOL3: begin
        cw.we     = 1'b1;
        cw.wa_sel = WA_I;
        cw.wd_sel = WD_SWAP_RD;
      end
      A_SOL4: begin
        cw.we      = 1'b1;
        cw.wa_sel  = WA_J;
        cw.wd_sel  = WD_SWAP_TMP;
        cw.ra_sel  = RA_I_NEXT;
        cw.step_ij = 1'b1;
        cw.cond    = COND_MORE;
        cw.target  = A_SOL2;
      end
      A_SOL5: begin
        cw.add_en   = 1'b1;
        cw.wd_sel   = WD_STOP;
        cw.rpos_clr = 1'b1;
        cw.cond     = COND_ALWAYS;
        cw.target   = A_EMIT;
      end
      // replay one entry
      A_RPL0: begin
        cw.ra_sel = RA_RPOS;
        cw.cond   = COND_RPOS_END;
        cw.target = A_EMIT;
      end
      A_RPL1: begin
        cw.t_ld_rd  = 1'b1;
        cw.rpos_inc = 1'b1;
        cw.cond     = COND_ALWAYS;
        cw.target   = A_EMIT;
      end
      A_CLR0: begin
        cw.clr    = 1'b1;
        cw.cond   = COND_ALWAYS;
        cw.target = A_EMIT;
      end
      A_EMIT: begin
        cw.out_ld = 1'b1;
        cw.cond   = COND_OUT_BUSY;
        cw.target = A_EMIT;
        cw.ret    = 1'b1;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = A_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

### rtl/lmpr_ram.sv
module lmpr_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lmpr_seq.sv
module lmpr_seq
  import lmpr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  flags_t flags_i,
  output cw_t    cw_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  cw_t              cw;
  logic             jump;

  assign cw = ucode(upc_q);

  // Evaluate the branch condition of the current step
  always_comb begin
    unique case (cw.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = ~in_valid_i;
      COND_DISPATCH: jump = 1'b1;
      COND_LT3:      jump = flags_i.lt3;
      COND_NOT_U:    jump = flags_i.not_u;
      COND_CNT_ZERO: jump = flags_i.cnt_zero;
      COND_MORE:     jump = flags_i.more;
      COND_RPOS_END: jump = flags_i.rpos_end;
      COND_OUT_BUSY: jump = flags_i.out_busy;
      default:       jump = 1'b0;
    endcase
  end

  // Pick the next step
  always_comb begin
    if (cw.cond == COND_DISPATCH) begin
      upc_d = dispatch_target(flags_i.cls);
    end else if (jump) begin
      upc_d = cw.target;
    end else if (cw.ret) begin
      upc_d = A_IDLE;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= A_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign cw_o = cw;

endmodule

### rtl/lmpr_dp.sv
module lmpr_dp
  import lmpr_pkg::*;
#(
  parameter int PATH_DEPTH = PATH_DEPTH_C
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cw_t               cw_i,
  input  logic              in_valid_i,
  input  logic [2:0]        opcode_i,
  input  logic [2:0]        prev_kind_i,
  input  logic [2:0]        curr_kind_i,
  input  logic              cfg_we_i,
  input  logic              left_hand_rule_i,
  input  logic              out_stall_i,
  output flags_t            flags_o,
  output logic              out_valid_o,
  output logic [2:0]        turn_o,
  output logic [1:0]        status_o,
  output logic [PCNT_W-1:0] path_count_o,
  output logic              solved_flag_o
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int CW = $clog2(PATH_DEPTH + 1);

  // Control state
  logic          lh_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] rpos_q;
  logic          solved_q;
  logic          out_valid_q;

  // Working registers
  logic [2:0]    op_q, prev_q, curr_q;
  logic [2:0]    t_q, rec_q, tmp_q;
  logic [1:0]    st_q;
  logic [1:0]    acc_q;
  logic [AW-1:0] i_q, j_q;
  logic [2:0]    out_turn_q;
  logic [1:0]    out_status_q;
  logic [CW-1:0] out_cnt_q;
  logic          out_solved_q;

  logic          accept, full, out_busy;
  logic [2:0]    fwd_t, bwd_t, sel_t, sel_rec;
  logic [1:0]    sel_st;
  dcls_e         cls;
  logic [CW-1:0] cnt_m1, cnt_m2, cnt_m3;
  logic          mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [2:0]    wdata, rdata;
  logic [1:0]    acc_sum;

  assign accept   = cw_i.accept & in_valid_i;
  assign full     = (cnt_q >= CW'(PATH_DEPTH));
  assign out_busy = out_valid_q & out_stall_i;
  assign cnt_m1   = cnt_q - CW'(1);
  assign cnt_m2   = cnt_q - CW'(2);
  assign cnt_m3   = cnt_q - CW'(3);
  assign acc_sum  = acc_q + quarter_of(rdata);

  // Decode the item into a turn, a status and a class
  assign fwd_t = sel_fwd(prev_q, curr_q, lh_q);
  assign bwd_t = sel_bwd(prev_q, curr_q, lh_q);

  always_comb begin
    sel_t   = T_STOP;
    sel_st  = ST_OK;
    sel_rec = T_STOP;
    cls     = CLS_EMIT;
    unique case (op_q)
      OP_FWD: begin
        sel_t   = fwd_t;
        sel_rec = fwd_t;
        if (fwd_t == T_FINISH) begin
          sel_st = ST_FINISH;
        end else if (fwd_t == T_STOP) begin
          sel_st = ST_FAILED;
        end else begin
          cls = CLS_RECORD;
        end
      end
      OP_BWD: begin
        sel_t   = bwd_t;
        sel_rec = mirror_turn(bwd_t);
        if (bwd_t == T_STOP) begin
          sel_st = ST_FAILED;
        end else begin
          cls = CLS_RECORD;
        end
      end
      OP_DEAD: begin
        sel_t   = T_LEFT180;
        sel_rec = T_LEFT180;
        cls     = CLS_RECORD;
      end
      OP_SOLVE:  cls = CLS_SOLVE;
      OP_REPLAY: cls = CLS_REPLAY;
      OP_CLEAR:  cls = CLS_CLEAR;
      default:   sel_st = ST_FAILED;
    endcase
  end

  // Select store addresses and write data
  always_comb begin
    unique case (cw_i.ra_sel)
      RA_CNT_M1: raddr = cnt_m1[AW-1:0];
      RA_CNT_M2: raddr = cnt_m2[AW-1:0];
      RA_CNT_M3: raddr = cnt_m3[AW-1:0];
      RA_I:      raddr = i_q;
      RA_I_NEXT: raddr = i_q + AW'(1);
      RA_J:      raddr = j_q;
      RA_RPOS:   raddr = rpos_q[AW-1:0];
      default:   raddr = i_q;
    endcase
  end

  always_comb begin
    if (cw_i.add_en) begin
      waddr = cnt_q[AW-1:0];
    end else begin
      unique case (cw_i.wa_sel)
        WA_CNT_M3: waddr = cnt_m3[AW-1:0];
        WA_I:      waddr = i_q;
        WA_J:      waddr = j_q;
        default:   waddr = j_q;
      endcase
    end
  end

  always_comb begin
    unique case (cw_i.wd_sel)
      WD_REC:      wdata = rec_q;
      WD_STOP:     wdata = T_STOP;
      WD_RED:      wdata = turn_of_quarter(acc_sum);
      WD_SWAP_RD:  wdata = swap_sides(rdata);
      WD_SWAP_TMP: wdata = swap_sides(tmp_q);
      default:     wdata = rec_q;
    endcase
  end

  assign mem_we = cw_i.we | (cw_i.add_en & ~full);

  lmpr_ram #(
    .WIDTH(3),
    .DEPTH(PATH_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lh_q        <= 1'b1;
      cnt_q       <= '0;
      rpos_q      <= '0;
      solved_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lh_q <= left_hand_rule_i;
      end
      if (cw_i.clr) begin
        cnt_q <= '0;
      end else if (cw_i.add_en && !full) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cw_i.sub2) begin
        cnt_q <= cnt_m2;
      end
      if (cw_i.clr || cw_i.rpos_clr) begin
        rpos_q <= '0;
      end else if (cw_i.rpos_inc) begin
        rpos_q <= rpos_q + CW'(1);
      end
      if (cw_i.clr) begin
        solved_q <= 1'b0;
      end else if (cw_i.solve_init) begin
        solved_q <= 1'b1;
      end
      if (cw_i.out_ld && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      prev_q <= prev_kind_i;
      curr_q <= curr_kind_i;
    end
    if (cw_i.ld_sel) begin
      t_q   <= sel_t;
      rec_q <= sel_rec;
    end else if (cw_i.t_ld_rd) begin
      t_q <= rdata;
    end
    if (cw_i.ld_sel) begin
      st_q <= sel_st;
    end else if (cw_i.add_en && full) begin
      st_q <= ST_FULL;
    end
    unique case (cw_i.acc_op)
      ACC_LOAD: acc_q <= quarter_of(rdata);
      ACC_ADD:  acc_q <= acc_sum;
      default:  acc_q <= acc_q;
    endcase
    if (cw_i.tmp_ld) begin
      tmp_q <= rdata;
    end
    if (cw_i.solve_init) begin
      i_q <= '0;
      j_q <= cnt_m1[AW-1:0];
    end else if (cw_i.step_ij) begin
      i_q <= i_q + AW'(1);
      j_q <= j_q - AW'(1);
    end
    if (cw_i.out_ld && !out_busy) begin
      out_turn_q   <= t_q;
      out_status_q <= st_q;
      out_cnt_q    <= cnt_q;
      out_solved_q <= solved_q;
    end
  end

  // Conditions for the sequencer
  assign flags_o.cls      = cls;
  assign flags_o.lt3      = (cnt_q < CW'(3));
  assign flags_o.not_u    = ~(rdata == T_LEFT180 || rdata == T_RIGHT180);
  assign flags_o.cnt_zero = (cnt_q == '0);
  assign flags_o.more     = ((j_q - i_q) >= AW'(2));
  assign flags_o.rpos_end = (rpos_q >= cnt_q);
  assign flags_o.out_busy = out_busy;

  assign out_valid_o   = out_valid_q;
  assign turn_o        = out_turn_q;
  assign status_o      = out_status_q;
  assign path_count_o  = PCNT_W'(out_cnt_q);
  assign solved_flag_o = out_solved_q;

endmodule

### rtl/line_maze_path_recorder.sv
// One item at a time; the block returns to its idle step to take the next item once the result is registered,
// and a stalled result holds the block until it is taken.
// Reset clears count, replay position and solved flag and sets the left-hand rule, not the store.
module line_maze_path_recorder
  import lmpr_pkg::*;
#(
  parameter int PATH_DEPTH = PATH_DEPTH_C
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        opcode_i,
  input  logic [2:0]        prev_kind_i,
  input  logic [2:0]        curr_kind_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        turn_o,
  output logic [1:0]        status_o,
  output logic [PCNT_W-1:0] path_count_o,
  output logic              solved_flag_o,
  input  logic              cfg_we_i,
  input  logic              left_hand_rule_i
);

  cw_t    cw;
  flags_t flags;

  // Take an item only in the idle step
  assign in_stall_o = ~cw.accept;

  lmpr_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .flags_i   (flags),
    .cw_o      (cw)
  );

  lmpr_dp #(
    .PATH_DEPTH(PATH_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cw_i            (cw),
    .in_valid_i      (in_valid_i),
    .opcode_i        (opcode_i),
    .prev_kind_i     (prev_kind_i),
    .curr_kind_i     (curr_kind_i),
    .cfg_we_i        (cfg_we_i),
    .left_hand_rule_i(left_hand_rule_i),
    .out_stall_i     (out_stall_i),
    .flags_o         (flags),
    .out_valid_o     (out_valid_o),
    .turn_o          (turn_o),
    .status_o        (status_o),
    .path_count_o    (path_count_o),
    .solved_flag_o   (solved_flag_o)
  );

endmodule

### rtl/lmpr_chk.sv
`include "line_maze_path_recorder_defines.svh"

module lmpr_chk
  import lmpr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [2:0]        turn_o,
  input logic [1:0]        status_o,
  input logic [PCNT_W-1:0] path_count_o,
  input logic              solved_flag_o
);

  // Finish status always carries the finish turn
  `LMPR_ASSERT(a_finish_turn, out_valid_o && status_o == ST_FINISH |-> turn_o == T_FINISH, "finish status without finish turn")

  // Failed status always carries the stop turn
  `LMPR_ASSERT(a_failed_turn, out_valid_o && status_o == ST_FAILED |-> turn_o == T_STOP, "failed status without stop turn")

  // Hold a stalled item
  `LMPR_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(turn_o) && $stable(status_o) && $stable(path_count_o) && $stable(solved_flag_o), "stalled item changed")

  // Keep the output idle in the cycle after reset is seen
  `LMPR_ASSERT_RST(a_rst_quiet, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind line_maze_path_recorder lmpr_chk u_lmpr_chk (.*);

### tb/line_maze_path_recorder_test.sv
module line_maze_path_recorder_test
  import lmpr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes the block must reject, and a kind outside the encoding
  localparam logic [2:0] OP_UNDEF_A = 3'd6;
  localparam logic [2:0] OP_UNDEF_B = 3'd7;
  localparam logic [2:0] K_UNUSED   = 3'd7;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS   = 125;

  // What the block should report for one item
  typedef struct packed {
    logic [2:0]        turn;
    logic [1:0]        status;
    logic [PCNT_W-1:0] count;
    logic              solved;
  } path_report_t;

  // Tracks the recorded path and the reports still owed by the block
  class maze_path_tracker;
    logic [2:0]   turns [PATH_DEPTH_C];
    int unsigned  stored;
    int unsigned  replay_at;
    bit           solved;
    bit           hand_left;
    path_report_t due [$];
    int unsigned  errors, checked, deepest, folds, drops, finishes;

    function new();
      stored    = 0;
      replay_at = 0;
      solved    = 1'b0;
      hand_left = 1'b1;
      errors    = 0;
      checked   = 0;
      deepest   = 0;
      folds     = 0;
      drops     = 0;
      finishes  = 0;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // Turn taken when driving forward through an intersection
    function logic [2:0] forward_turn(logic [2:0] p, logic [2:0] c);
      case ({p, c})
        {K_NONE, K_NONE}:                      return hand_left ? T_RIGHT180 : T_LEFT180;
        {K_FULL, K_NONE}, {K_FULL, K_STRAIGHT}: return hand_left ? T_LEFT90 : T_RIGHT90;
        {K_RIGHT, K_NONE}:                     return T_RIGHT90;
        {K_LEFT, K_NONE}:                      return T_LEFT90;
        {K_FULL, K_FULL}:                      return T_FINISH;
        {K_RIGHT, K_STRAIGHT}:                 return hand_left ? T_STRAIGHT : T_RIGHT90;
        {K_LEFT, K_STRAIGHT}:                  return hand_left ? T_LEFT90 : T_STRAIGHT;
        default:                               return T_STOP;
      endcase
    endfunction

    // Turn taken when driving back through an intersection
    function logic [2:0] backward_turn(logic [2:0] p, logic [2:0] c);
      case ({p, c})
        {K_LEFT, K_NONE}:                      return T_LEFT90;
        {K_RIGHT, K_NONE}:                     return T_RIGHT90;
        {K_RIGHT, K_STRAIGHT}:                 return hand_left ? T_RIGHT90 : T_LEFT180;
        {K_LEFT, K_STRAIGHT}:                  return hand_left ? T_RIGHT180 : T_LEFT90;
        {K_FULL, K_NONE}, {K_FULL, K_STRAIGHT}: return hand_left ? T_RIGHT90 : T_LEFT90;
        default:                               return T_STOP;
      endcase
    endfunction

    function logic [2:0] mirrored(logic [2:0] t);
      case (t)
        T_LEFT90:                          return T_RIGHT90;
        T_RIGHT90:                         return T_LEFT90;
        T_LEFT180, T_RIGHT180, T_STRAIGHT: return T_STRAIGHT;
        default:                           return T_STOP;
      endcase
    endfunction

    function logic [2:0] side_swapped(logic [2:0] t);
      if (t == T_LEFT90) return T_RIGHT90;
      if (t == T_RIGHT90) return T_LEFT90;
      return t;
    endfunction

    // Clockwise angle of a turn in degrees
    function int unsigned degrees(logic [2:0] t);
      case (t)
        T_LEFT90:              return 270;
        T_RIGHT90:             return 90;
        T_LEFT180, T_RIGHT180: return 180;
        default:               return 0;
      endcase
    endfunction

    // Append one turn, or drop it when the store is full
    function logic [1:0] push_turn(logic [2:0] t);
      if (stored < PATH_DEPTH_C) begin
        turns[stored] = t;
        stored++;
        if (stored > deepest) deepest = stored;
        return ST_OK;
      end
      drops++;
      return ST_FULL;
    endfunction

    // Collapse turn, U-turn, turn into the single equivalent turn
    function void fold_tail();
      int unsigned n, sum;
      logic [2:0]  mid;
      n = stored;
      if (n < 3) return;
      mid = turns[n-2];
      if (mid != T_LEFT180 && mid != T_RIGHT180) return;
      sum = (degrees(turns[n-1]) + degrees(mid) + degrees(turns[n-3])) % 360;
      case (sum)
        90:      turns[n-3] = T_RIGHT90;
        180:     turns[n-3] = T_LEFT180;
        270:     turns[n-3] = T_LEFT90;
        default: turns[n-3] = T_STRAIGHT;
      endcase
      stored = n - 2;
      folds++;
    endfunction

    function logic [1:0] record(logic [2:0] t);
      logic [1:0] st;
      st = push_turn(t);
      fold_tail();
      return st;
    endfunction

    // Run the path backward with left and right exchanged
    function void reverse_path();
      logic [2:0] old [PATH_DEPTH_C];
      old = turns;
      for (int unsigned i = 0; i < stored; i++) turns[i] = side_swapped(old[stored-1-i]);
    endfunction

    // Advance the path state by one accepted item and queue its report
    function void take_command(logic [2:0] op, logic [2:0] p, logic [2:0] c);
      path_report_t r;
      logic [2:0]   t;
      logic [1:0]   st;
      t  = T_STOP;
      st = ST_OK;
      case (op)
        OP_FWD: begin
          t = forward_turn(p, c);
          if (t == T_FINISH) begin
            st = ST_FINISH;
            finishes++;
          end else if (t == T_STOP) st = ST_FAILED;
          else st = record(t);
        end
        OP_BWD: begin
          t = backward_turn(p, c);
          if (t == T_STOP) st = ST_FAILED;
          else st = record(mirrored(t));
        end
        OP_DEAD: begin
          t  = T_LEFT180;
          st = record(T_LEFT180);
        end
        OP_SOLVE: begin
          solved = 1'b1;
          reverse_path();
          st = push_turn(T_STOP);
          replay_at = 0;
        end
        OP_REPLAY: begin
          if (replay_at < stored) begin
            t = turns[replay_at];
            replay_at++;
          end
        end
        OP_CLEAR: begin
          solved    = 1'b0;
          stored    = 0;
          replay_at = 0;
        end
        default: st = ST_FAILED;
      endcase
      r.turn   = t;
      r.status = st;
      r.count  = PCNT_W'(stored);
      r.solved = solved;
      due.push_back(r);
    endfunction

    // Compare one delivered report with the oldest one owed
    function void match_report(logic [2:0] turn, logic [1:0] status,
                               logic [PCNT_W-1:0] count, logic solved_f);
      path_report_t e;
      if (due.size() == 0) begin
        $error("result with no item outstanding: turn %0d status %0d", turn, status);
        errors++;
        return;
      end
      e = due.pop_front();
      checked++;
      if (turn !== e.turn) begin
        $error("turn: expected %0d, actual %0d", e.turn, turn);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (count !== e.count) begin
        $error("path_count: expected %0d, actual %0d", e.count, count);
        errors++;
      end
      if (solved_f !== e.solved) begin
        $error("solved_flag: expected %0d, actual %0d", e.solved, solved_f);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [2:0]        opcode_i         = OP_CLEAR;
  logic [2:0]        prev_kind_i      = K_NONE;
  logic [2:0]        curr_kind_i      = K_NONE;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [2:0]        turn_o;
  logic [1:0]        status_o;
  logic [PCNT_W-1:0] path_count_o;
  logic              solved_flag_o;
  logic              cfg_we_i         = 1'b0;
  logic              left_hand_rule_i = 1'b1;

  maze_path_tracker board;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      items_sent    = 0;
  int unsigned      cycle_count   = 0;

  line_maze_path_recorder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .prev_kind_i     (prev_kind_i),
    .curr_kind_i     (curr_kind_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .turn_o          (turn_o),
    .status_o        (status_o),
    .path_count_o    (path_count_o),
    .solved_flag_o   (solved_flag_o),
    .cfg_we_i        (cfg_we_i),
    .left_hand_rule_i(left_hand_rule_i)
  );

  always #1 clk_i = ~clk_i;

  // Check delivered results and stall the output at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.match_report(turn_o, status_o, path_count_o, solved_flag_o);
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one item, idling first at random, and hold it until taken
  task automatic send_command(input logic [2:0] op, input logic [2:0] p, input logic [2:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    prev_kind_i <= p;
    curr_kind_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_command(op, p, c);
    items_sent++;
  endtask

  // Drop valid and wait until every report is in, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_hand_rule(input logic left);
    settle();
    cfg_we_i         <= 1'b1;
    left_hand_rule_i <= left;
    @(posedge clk_i);
    board.hand_left = left;
    cfg_we_i        <= 1'b0;
  endtask

  // Kind pairs that some forward rule matches
  function automatic logic [5:0] forward_pair(input int unsigned k);
    case (k)
      0:       return {K_NONE, K_NONE};
      1:       return {K_FULL, K_NONE};
      2:       return {K_RIGHT, K_NONE};
      3:       return {K_LEFT, K_NONE};
      4:       return {K_FULL, K_STRAIGHT};
      5:       return {K_FULL, K_FULL};
      6:       return {K_RIGHT, K_STRAIGHT};
      default: return {K_LEFT, K_STRAIGHT};
    endcase
  endfunction

  // Kind pairs that some backward rule matches
  function automatic logic [5:0] backward_pair(input int unsigned k);
    case (k)
      0:       return {K_LEFT, K_NONE};
      1:       return {K_RIGHT, K_NONE};
      2:       return {K_RIGHT, K_STRAIGHT};
      3:       return {K_LEFT, K_STRAIGHT};
      4:       return {K_FULL, K_NONE};
      default: return {K_FULL, K_STRAIGHT};
    endcase
  endfunction

  task automatic run_directed();
    set_hand_rule(1'b1);
    // empty store: replay runs past the end, solve appends only a stop
    send_command(OP_REPLAY, K_NONE, K_NONE);
    send_command(OP_SOLVE, K_NONE, K_NONE);
    send_command(OP_CLEAR, K_UNUSED, K_UNUSED);
    // every forward rule, the finish and an out-of-range pair
    send_command(OP_FWD, K_NONE, K_NONE);
    send_command(OP_FWD, K_FULL, K_NONE);
    send_command(OP_FWD, K_RIGHT, K_NONE);
    send_command(OP_FWD, K_LEFT, K_NONE);
    send_command(OP_FWD, K_FULL, K_STRAIGHT);
    send_command(OP_FWD, K_FULL, K_FULL);
    send_command(OP_FWD, K_RIGHT, K_STRAIGHT);
    send_command(OP_FWD, K_LEFT, K_STRAIGHT);
    send_command(OP_FWD, K_UNUSED, 3'd5);
    // backward U-turn records straight; an unmatched backward pair fails
    send_command(OP_BWD, K_LEFT, K_STRAIGHT);
    send_command(OP_BWD, K_NONE, K_FULL);
    // dead end followed by a turn folds the U-turn away
    send_command(OP_DEAD, K_NONE, K_NONE);
    send_command(OP_FWD, K_RIGHT, K_NONE);
    send_command(OP_UNDEF_A, K_FULL, K_FULL);
    send_command(OP_UNDEF_B, K_UNUSED, K_UNUSED);
    // solve, replay from the start, solve again over the stop
    send_command(OP_SOLVE, K_NONE, K_NONE);
    send_command(OP_REPLAY, K_NONE, K_NONE);
    send_command(OP_SOLVE, K_NONE, K_NONE);
    // right-hand rule variants
    set_hand_rule(1'b0);
    send_command(OP_FWD, K_NONE, K_NONE);
    send_command(OP_FWD, K_RIGHT, K_STRAIGHT);
    send_command(OP_FWD, K_LEFT, K_STRAIGHT);
    send_command(OP_BWD, K_RIGHT, K_STRAIGHT);
    send_command(OP_BWD, K_LEFT, K_STRAIGHT);
    send_command(OP_BWD, K_FULL, K_NONE);
    send_command(OP_CLEAR, K_NONE, K_NONE);
  endtask

  // Mostly matched observations and dead ends, a few stray kind pairs
  task automatic walk_maze(input int unsigned len);
    logic [2:0]  p, c;
    int unsigned r;
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        {p, c} = forward_pair($urandom_range(0, 7));
        send_command(OP_FWD, p, c);
      end else if (r < 72) begin
        {p, c} = backward_pair($urandom_range(0, 5));
        send_command(OP_BWD, p, c);
      end else if (r < 90) begin
        send_command(OP_DEAD, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      end else begin
        send_command(r[0] ? OP_BWD : OP_FWD, 3'($urandom_range(0, 7)),
                     3'($urandom_range(0, 7)));
      end
    end
  endtask

  // Solve, sometimes twice, then replay part or all of the path
  task automatic solve_and_replay();
    int unsigned reps, cap;
    send_command(OP_SOLVE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    if ($urandom_range(0, 3) == 0) send_command(OP_SOLVE, K_NONE, K_NONE);
    cap  = (board.stored + 2 > 16) ? 16 : board.stored + 2;
    reps = $urandom_range(1, cap);
    repeat (reps) send_command(OP_REPLAY, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
  endtask

  // Push the store to full, then try records and a solve that must drop
  task automatic fill_path();
    logic [2:0] p;
    int unsigned guard;
    guard = 0;
    while (board.stored < PATH_DEPTH_C && guard < 100) begin
      case ($urandom_range(0, 2))
        0:       p = K_LEFT;
        1:       p = K_RIGHT;
        default: p = K_FULL;
      endcase
      send_command(OP_FWD, p, K_NONE);
      guard++;
    end
    send_command(OP_BWD, K_LEFT, K_NONE);
    send_command(OP_DEAD, K_NONE, K_NONE);
    send_command(OP_FWD, K_NONE, K_NONE);
    solve_and_replay();
    if ($urandom_range(0, 1) == 0) send_command(OP_CLEAR, K_NONE, K_NONE);
  endtask

  task automatic noise_burst(input int unsigned len);
    repeat (len) begin
      send_command(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)));
    end
  endtask

  task automatic run_phase(input logic left, input int unsigned s_pct, input int unsigned r_pct);
    int unsigned stop_at, pick;
    bit          filled;
    set_hand_rule(left);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = items_sent + PHASE_ITEMS;
    filled  = 1'b0;
    while (items_sent < stop_at) begin
      if (!filled && items_sent + PHASE_ITEMS / 2 >= stop_at) begin
        fill_path();
        filled = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) walk_maze($urandom_range(3, 12));
        else if (pick < 75) solve_and_replay();
        else if (pick < 88) noise_burst($urandom_range(1, 4));
        else send_command(OP_CLEAR, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    board = new();
    send_idle_pct = 29;
    recv_idle_pct = 60;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    // sender sparse, receiver busy; then swapped; then full rate
    run_phase(1'b1, 29, 60);
    run_phase(1'b0, 60, 29);
    run_phase(1'b1, 0, 0);
    settle();
    $display("Checked %0d results from %0d items, both hand rules, three idling mixes.",
             board.checked, items_sent);
    $display("Deepest path %0d turns, %0d folds, %0d dropped entries, %0d finishes.",
             board.deepest, board.folds, board.drops, board.finishes);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
